// ===== rtl/core/sfr_pkg.sv =====
// ---------------------------------------------------------------------------
// sfr_pkg: shared types and CRC helpers for the sync frame receiver
// Holds the sync word, the CRC-16 constants, the byte-wide CRC step and the
// result record that moves from the frame parser to the output buffer.
// ---------------------------------------------------------------------------
package sfr_pkg;

  // Sync bytes on the wire: low byte first (0xCA, then 0xFE)
  localparam logic [15:0] SYNC_WORD = 16'hFECA;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam logic [7:0]  BYTE_MASK = 8'hFF;

  typedef struct packed {
    logic       is_end;
    logic [7:0] payload_byte;
    logic [7:0] byte_index;
    logic       crc_ok;
    logic [7:0] payload_length;
  } sfr_res_t;

  // One reflected CRC-16 step over a full byte, LSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // CRC state after the two sync bytes; folds to a constant
  localparam logic [15:0] CRC_SYNC =
    crc_byte(crc_byte(CRC_INIT, SYNC_WORD[7:0]), SYNC_WORD[15:8]);

  // CRC state after sync bytes and the device id (low byte first)
  function automatic logic [15:0] crc_hdr(input logic [15:0] dev_id);
    return crc_byte(crc_byte(CRC_SYNC, dev_id[7:0]), dev_id[15:8]);
  endfunction

endpackage

// ===== rtl/core/sfr_frame.sv =====
// ---------------------------------------------------------------------------
// sfr_frame: header hunt, payload tracking and running CRC
// Slides a four-byte window to find the sync/id header, then counts the
// payload and CRC bytes; one result per payload byte and one at frame end.
// ---------------------------------------------------------------------------
module sfr_frame
  import sfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        beat_vld,
  input  logic [7:0]  beat_byte,
  output logic        res_vld,
  output sfr_res_t    res
);

  logic        receiving_r, receiving_nxt;
  logic [31:0] recent_r;
  logic [8:0]  bytes_left_r, bytes_left_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;
  logic [7:0]  frame_len_r, frame_len_nxt;
  logic [7:0]  idx_r, idx_nxt;
  logic [15:0] dev_id_r;
  logic [15:0] hdr_crc_r;
  logic        hdr_hit;

  assign hdr_hit = (recent_r[31:24] == SYNC_WORD[7:0]) &&
                   (recent_r[23:16] == SYNC_WORD[15:8]) &&
                   ({recent_r[7:0], recent_r[15:8]} == dev_id_r);

  always_comb begin
    receiving_nxt  = receiving_r;
    bytes_left_nxt = bytes_left_r;
    crc_nxt        = crc_r;
    crc_lo_nxt     = crc_lo_r;
    frame_len_nxt  = frame_len_r;
    idx_nxt        = idx_r;
    res_vld        = 1'b0;
    res            = '0;
    if (beat_vld) begin
      if (!receiving_r) begin
        if (hdr_hit) begin
          crc_nxt        = crc_byte(hdr_crc_r, beat_byte);
          frame_len_nxt  = beat_byte;
          bytes_left_nxt = {1'b0, beat_byte} + 9'd2;
          idx_nxt        = 8'd0;
          receiving_nxt  = 1'b1;
        end
      end else if (bytes_left_r > 9'd2) begin
        crc_nxt            = crc_byte(crc_r, beat_byte);
        bytes_left_nxt     = bytes_left_r - 9'd1;
        idx_nxt            = idx_r + 8'd1;
        res_vld            = 1'b1;
        res.payload_byte   = beat_byte;
        res.byte_index     = idx_r;
      end else if (bytes_left_r == 9'd2) begin
        crc_lo_nxt     = beat_byte;
        bytes_left_nxt = 9'd1;
      end else begin
        // last CRC byte closes the frame
        res_vld            = 1'b1;
        res.is_end         = 1'b1;
        res.crc_ok         = ({beat_byte, crc_lo_r} == crc_r);
        res.payload_length = frame_len_r & BYTE_MASK;
        bytes_left_nxt     = 9'd0;
        receiving_nxt      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      receiving_r  <= 1'b0;
      recent_r     <= '0;
      bytes_left_r <= '0;
      crc_r        <= CRC_INIT;
      crc_lo_r     <= '0;
      frame_len_r  <= '0;
      idx_r        <= '0;
      dev_id_r     <= '0;
      hdr_crc_r    <= crc_hdr(16'h0000);
    end else begin
      if (beat_vld) begin
        recent_r <= {recent_r[23:0], beat_byte};
      end
      receiving_r  <= receiving_nxt;
      bytes_left_r <= bytes_left_nxt;
      crc_r        <= crc_nxt;
      crc_lo_r     <= crc_lo_nxt;
      frame_len_r  <= frame_len_nxt;
      idx_r        <= idx_nxt;
      // precompute the header CRC so the hunt needs a single byte step
      if (cfg_we) begin
        dev_id_r  <= cfg_data;
        hdr_crc_r <= crc_hdr(cfg_data);
      end
    end
  end

  a_idle_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    !receiving_r |-> (bytes_left_r == 9'd0))
    else $error("byte count left over while hunting");

  a_rx_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    receiving_r |-> (bytes_left_r != 9'd0) && (bytes_left_r <= 9'd257))
    else $error("byte count out of range in a frame");

  a_res_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |-> receiving_r && beat_vld)
    else $error("result produced outside a frame");

  a_idx_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (receiving_r && bytes_left_r > 9'd2) |->
      ({1'b0, idx_r} + bytes_left_r == {1'b0, frame_len_r} + 9'd2))
    else $error("payload index out of step with byte count");

endmodule

// ===== rtl/core/sfr_outq.sv =====
// ---------------------------------------------------------------------------
// sfr_outq: two-entry result buffer
// Output register plus a skid entry, so an input beat is taken while a
// finished result still waits on a stalled output.
// ---------------------------------------------------------------------------
module sfr_outq
  import sfr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  sfr_res_t push_res,
  input  logic     out_stall,
  output logic     out_valid,
  output sfr_res_t out_res,
  output logic     full
);

  logic     out_vld_r;
  logic     skid_vld_r;
  sfr_res_t out_res_r;
  sfr_res_t skid_res_r;
  logic     take;

  assign take = out_vld_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      // drain the skid entry first; input is held off meanwhile
      if (take) begin
        skid_vld_r <= 1'b0;
      end
    end else if (!out_vld_r || take) begin
      out_vld_r <= push;
    end else if (push) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (take) begin
        out_res_r <= skid_res_r;
      end
    end else if (!out_vld_r || take) begin
      out_res_r <= push_res;
    end else if (push) begin
      skid_res_r <= push_res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_res   = out_res_r;
  assign full      = skid_vld_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid entry valid with empty output register");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> !push)
    else $error("result pushed into a full buffer");

  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_vld_r && take) |=> out_vld_r && !skid_vld_r)
    else $error("skid entry lost on drain");

endmodule

// ===== rtl/core/sync_frame_receiver_crc16.sv =====
// ---------------------------------------------------------------------------
// sync_frame_receiver_crc16: sync-word frame receiver with CRC-16 check
// Hunts for 0xCA 0xFE + device id + length, emits each payload byte with
// its index and ends each frame with a CRC-16 (0xA001 reflected) verdict.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_stall   | in_rx_byte
//   out_    | output    | out_valid / out_stall | is_end, payload_byte,
//           |           |                       | byte_index, crc_ok,
//           |           |                       | payload_length
//   cfg_    | input     | cfg_we                | cfg_data (device id)
//
// One beat per cycle while in_stall is low: parse and CRC step are
// combinational (one byte-wide CRC step) and registered in the output buffer.
// Synchronous active-low reset; no clearing pass, ready right after reset.
// A two-entry output buffer stalls input only when both entries hold results.
// ---------------------------------------------------------------------------
module sync_frame_receiver_crc16
  import sfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_is_end,
  output logic [7:0]  out_payload_byte,
  output logic [7:0]  out_byte_index,
  output logic        out_crc_ok,
  output logic [7:0]  out_payload_length
);

  logic     beat_vld;
  logic     res_vld;
  sfr_res_t res;
  sfr_res_t out_res;
  logic     q_full;

  assign in_stall = q_full;
  assign beat_vld = in_valid && !q_full;

  sfr_frame u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .beat_vld  (beat_vld),
    .beat_byte (in_rx_byte),
    .res_vld   (res_vld),
    .res       (res)
  );

  sfr_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_vld),
    .push_res  (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res),
    .full      (q_full)
  );

  assign out_is_end         = out_res.is_end;
  assign out_payload_byte   = out_res.payload_byte;
  assign out_byte_index     = out_res.byte_index;
  assign out_crc_ok         = out_res.crc_ok;
  assign out_payload_length = out_res.payload_length;

endmodule
